### hw/rtl/sdt_pkg.sv
// Shared types, constants and helper functions for the signal detection table.
// Used by sdt_ctrl, sdt_datapath and signal_detection_table.
package sdt_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam logic [31:0] AGE_LIMIT_RST = 32'd60000;
    localparam logic [7:0] NEAR_THR_RST = 8'd85;

    localparam logic CMD_OBSERVE = 1'b0;
    localparam logic CMD_PURGE = 1'b1;

    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_PURGED = 2'd2;

    localparam logic CFG_AGE_LIMIT = 1'b0;
    localparam logic CFG_NEAR_THR = 1'b1;

    // ceil(2^22 / 70); exact floor division by 70 for dividends below 2^16.
    localparam logic [16:0] RECIP_70 = 17'd59919;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input item, clear the scan index
        logic rd;        // issue a read of the scan entry, advance the index
        logic step;      // evaluate the returned entry
        logic finish;    // commit the end of the item and build the result
    } sdt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_purge;
        logic scan_end;  // index has reached the valid count
        logic hit;       // observe has found its key
    } sdt_stat_t;

    // Normalised strength: 255 - trunc((r+100)*255/70), clamped to 0..255.
    // The division by 70 is a multiplication by its reciprocal; the magnitude
    // of (r+100)*255 never exceeds 57885, well inside the exact range.
    function automatic logic [7:0] norm_strength(input logic [7:0] raw);
        int a;
        logic [15:0] mag;
        logic [32:0] prod;
        int q;
        int n;
        a = int'($signed(raw)) + 100;
        if (a >= 0) begin
            mag = 16'(a * 255);
        end else begin
            mag = 16'((-a) * 255);
        end
        prod = 33'(mag) * 33'(RECIP_70);
        q = int'(prod[32:22]);
        if (a < 0) begin
            q = -q;
        end
        n = 255 - q;
        if (n < 0) begin
            n = 0;
        end
        if (n > 255) begin
            n = 255;
        end
        return n[7:0];
    endfunction

endpackage

### hw/rtl/sdt_ctrl.sv
// Controller state machine for the signal detection table.
// Depends on sdt_pkg for the command and status structs.
module sdt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                res_valid,
    input  logic                res_ready,
    output sdt_pkg::sdt_cmd_t   cmd,
    input  sdt_pkg::sdt_stat_t  stat
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                // Stop scanning at the end of the table or on the first match.
                if (stat.scan_end || stat.hit) begin
                    state_next = S_DONE;
                end else begin
                    cmd.rd = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.step = 1'b1;
                state_next = S_READ;
            end
            S_DONE: begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/sdt_datapath.sv
// Datapath of the signal detection table: entry memory, scan index and result.
// Depends on sdt_pkg for structs, codes and the strength function.
module sdt_datapath #(
    parameter int ENTRIES = sdt_pkg::ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  sdt_pkg::sdt_cmd_t  cmd,
    output sdt_pkg::sdt_stat_t stat,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_cmd,
    input  logic [31:0]        in_now,
    input  logic [31:0]        in_name,
    input  logic [47:0]        in_addr,
    input  logic [1:0]         in_kind,
    input  logic [8:0]         in_chan,
    input  logic [7:0]         in_rssi,
    input  logic [30:0]        in_lat,
    input  logic [31:0]        in_lon,
    output logic [1:0]         res_status,
    output logic               res_alert,
    output logic               res_crossing,
    output logic [5:0]         res_slot,
    output logic [6:0]         res_count,
    output logic [6:0]         res_removed
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int KW = 32 + 48 + 2 + 9;
    localparam int PW = 8 + 31 + 32 + 32;
    localparam int SW = (IW < 6) ? IW : 6;

    // Key part and state part of an entry, in two memories.
    logic [KW-1:0] key_mem [ENTRIES];
    logic [PW-1:0] pay_mem [ENTRIES];

    logic [31:0]   age_limit_reg;
    logic [7:0]    near_thr_reg;
    logic [CW-1:0] count_reg;
    logic [IW-1:0] wslot_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] kept_reg;
    logic          hit_reg;
    logic [IW-1:0] hit_slot_reg;
    logic [7:0]    hit_rssi_reg;

    logic          op_reg;
    logic [31:0]   now_reg;
    logic [KW-1:0] key_reg;
    logic [7:0]    rssi_reg;
    logic [30:0]   lat_reg;
    logic [31:0]   lon_reg;

    logic [KW-1:0] rd_key_reg;
    logic [PW-1:0] rd_pay_reg;

    logic [31:0]   rd_time;
    logic [31:0]   age;
    logic          keep;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [KW-1:0] wr_key;
    logic [PW-1:0] wr_pay;
    logic          wr_key_en;
    logic [7:0]    n_now;
    logic [7:0]    n_prev;

    assign rd_time = rd_pay_reg[31:0];
    assign age = now_reg - rd_time;
    assign keep = (age <= age_limit_reg);
    assign n_now = sdt_pkg::norm_strength(rssi_reg);
    assign n_prev = sdt_pkg::norm_strength(hit_rssi_reg);

    assign stat.is_purge = op_reg;
    assign stat.scan_end = (idx_reg == count_reg);
    assign stat.hit = hit_reg;

    // Memory write port: compaction copy on purge, update or insert on finish.
    always_comb begin
        wr_en = 1'b0;
        wr_key_en = 1'b0;
        wr_addr = wslot_reg;
        wr_key = rd_key_reg;
        wr_pay = rd_pay_reg;
        if (cmd.step && op_reg == sdt_pkg::CMD_PURGE) begin
            wr_en = keep;
            wr_key_en = keep;
            wr_addr = kept_reg[IW-1:0];
        end else if (cmd.finish && op_reg == sdt_pkg::CMD_OBSERVE) begin
            wr_en = 1'b1;
            wr_key_en = !hit_reg;
            wr_addr = hit_reg ? hit_slot_reg : wslot_reg;
            wr_key = key_reg;
            wr_pay = {rssi_reg, lat_reg, lon_reg, now_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pay_mem[wr_addr] <= wr_pay;
        end
        if (wr_key_en) begin
            key_mem[wr_addr] <= wr_key;
        end
        if (cmd.rd) begin
            rd_key_reg <= key_mem[idx_reg[IW-1:0]];
            rd_pay_reg <= pay_mem[idx_reg[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= in_cmd;
            now_reg <= in_now;
            key_reg <= {in_name, in_addr, in_kind, in_chan};
            rssi_reg <= in_rssi;
            lat_reg <= in_lat;
            lon_reg <= in_lon;
        end
        if (cmd.step && rd_key_reg == key_reg) begin
            hit_slot_reg <= idx_reg[IW-1:0] - IW'(1);
            hit_rssi_reg <= rd_pay_reg[PW-1 -: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_limit_reg <= sdt_pkg::AGE_LIMIT_RST;
            near_thr_reg <= sdt_pkg::NEAR_THR_RST;
            count_reg <= '0;
            wslot_reg <= '0;
            idx_reg <= '0;
            kept_reg <= '0;
            hit_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == sdt_pkg::CFG_AGE_LIMIT) begin
                    age_limit_reg <= cfg_data;
                end else begin
                    near_thr_reg <= cfg_data[7:0];
                end
            end
            if (cmd.load) begin
                idx_reg <= '0;
                kept_reg <= '0;
                hit_reg <= 1'b0;
            end
            if (cmd.rd) begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.step) begin
                if (op_reg == sdt_pkg::CMD_PURGE) begin
                    if (keep) begin
                        kept_reg <= kept_reg + CW'(1);
                    end
                end else if (rd_key_reg == key_reg) begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.finish) begin
                if (op_reg == sdt_pkg::CMD_PURGE) begin
                    count_reg <= kept_reg;
                    wslot_reg <= (kept_reg == CW'(ENTRIES)) ? '0 : kept_reg[IW-1:0];
                end else if (!hit_reg) begin
                    wslot_reg <= (wslot_reg == IW'(ENTRIES - 1)) ? '0 : wslot_reg + IW'(1);
                    if (count_reg != CW'(ENTRIES)) begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
            end
        end
    end

    // Result register, built when the item finishes.
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            res_crossing <= 1'b0;
            res_removed <= '0;
            res_slot <= '0;
            if (op_reg == sdt_pkg::CMD_PURGE) begin
                res_status <= sdt_pkg::ST_PURGED;
                res_alert <= 1'b0;
                res_count <= 7'(kept_reg);
                res_removed <= 7'(count_reg - kept_reg);
            end else if (hit_reg) begin
                res_status <= sdt_pkg::ST_UPDATED;
                res_alert <= (n_now <= near_thr_reg) && (n_prev > near_thr_reg);
                res_crossing <= (n_now <= near_thr_reg) && (n_prev > near_thr_reg);
                res_slot <= 6'(hit_slot_reg[SW-1:0]);
                res_count <= 7'(count_reg);
            end else begin
                res_status <= sdt_pkg::ST_INSERTED;
                res_alert <= 1'b1;
                res_slot <= 6'(wslot_reg[SW-1:0]);
                res_count <= (count_reg == CW'(ENTRIES)) ? 7'(count_reg)
                                                         : 7'(count_reg + CW'(1));
            end
        end
    end

endmodule

### hw/rtl/signal_detection_table.sv
// Top level of the signal detection table: controller plus datapath.
// Depends on sdt_pkg, sdt_ctrl and sdt_datapath.
//
//  Channel | Direction | Contents
//  s_      | in        | observe or purge item
//  m_      | out       | one result item per input item
//  cfg_    | in        | register writes (0 age limit, 1 near threshold)
//
// Each item is loaded, then each scanned entry is read from the entry memory and then
// evaluated, then the item is finished and its result is offered on m_. The scan
// covers entries up to the valid count, or up to the matching slot on observe.
// Reset is synchronous: it clears counters and control and restores the config defaults.
// A stalled result holds the block in its output state; no new item is taken.
module signal_detection_table #(
    parameter int ENTRIES = sdt_pkg::ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // now_ms[31:0], name_hash[63:32], device_address[111:64], radio_kind[113:112],
    // radio_channel[122:114], rssi_dbm[130:123], latitude[161:131],
    // longitude[193:162], zero fill to 200
    input  logic [199:0] s_tdata,
    // cmd
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], alert[2], crossing[3], slot[9:4], entry_count[16:10],
    // removed_count[23:17]
    output logic [23:0]  m_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    sdt_pkg::sdt_cmd_t  cmd;
    sdt_pkg::sdt_stat_t stat;

    logic [1:0] res_status;
    logic       res_alert;
    logic       res_crossing;
    logic [5:0] res_slot;
    logic [6:0] res_count;
    logic [6:0] res_removed;

    sdt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    sdt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_cmd       (s_tuser),
        .in_now       (s_tdata[31:0]),
        .in_name      (s_tdata[63:32]),
        .in_addr      (s_tdata[111:64]),
        .in_kind      (s_tdata[113:112]),
        .in_chan      (s_tdata[122:114]),
        .in_rssi      (s_tdata[130:123]),
        .in_lat       (s_tdata[161:131]),
        .in_lon       (s_tdata[193:162]),
        .res_status   (res_status),
        .res_alert    (res_alert),
        .res_crossing (res_crossing),
        .res_slot     (res_slot),
        .res_count    (res_count),
        .res_removed  (res_removed)
    );

    assign m_tdata = {res_removed, res_count, res_slot, res_crossing, res_alert, res_status};

endmodule

### dv/testbench.sv
// Self-checking testbench for signal_detection_table: observe and purge items in,
// one result item out, checked against a behavioural table model held here.
// Depends on sdt_pkg and the signal_detection_table RTL only.
`timescale 1ns / 100ps

module testbench;

    localparam int NENT = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] longitude;
        logic [30:0] latitude;
        logic [7:0]  rssi;
        logic [8:0]  channel;
        logic [1:0]  kind;
        logic [47:0] address;
        logic [31:0] name;
        logic [31:0] now;
    } obs_fields_t;

    typedef struct {
        logic        cmd;
        obs_fields_t f;
    } sig_item_t;

    typedef struct packed {
        logic [6:0] removed;
        logic [6:0] count;
        logic [5:0] slot;
        logic       crossing;
        logic       alert;
        logic [1:0] status;
    } table_result_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [199:0] s_tdata = '0;
    logic         s_tuser = sdt_pkg::CMD_OBSERVE;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    logic         cfg_we;
    logic         cfg_index;
    logic [31:0]  cfg_data;

    signal_detection_table uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Mirror of the table.
    logic [31:0] tbl_name [NENT];
    logic [47:0] tbl_addr [NENT];
    logic [1:0]  tbl_kind [NENT];
    logic [8:0]  tbl_chan [NENT];
    logic [7:0]  tbl_rssi [NENT];
    logic [30:0] tbl_lat [NENT];
    logic [31:0] tbl_lon [NENT];
    logic [31:0] tbl_time [NENT];
    int          tbl_count = 0;
    int          tbl_wslot = 0;
    logic [31:0] age_limit;
    logic [7:0]  near_thr;

    sig_item_t     pending_items[$];
    table_result_t expected_results[$];
    int            mismatches = 0;
    int            results_seen = 0;
    int            observes_sent = 0;
    int            purges_sent = 0;
    int            crossings_seen = 0;
    int            idle_cycles = 0;
    bit            hold_off_req = 1'b0;
    bit            hold_off_done = 1'b0;
    bit            hold_off_active;
    int            hold_off_left = 0;

    // Recently observed keys, so that random observes often hit existing entries.
    obs_fields_t   known_keys[$];

    function automatic int strength_of(input logic [7:0] raw);
        int a;
        int q;
        int n;
        a = $signed(raw) + 100;
        q = (a >= 0) ? (a * 255) / 70 : -(((-a) * 255) / 70);
        n = 255 - q;
        if (n < 0) n = 0;
        if (n > 255) n = 255;
        return n;
    endfunction

    function automatic table_result_t predict_table(input sig_item_t it);
        table_result_t r;
        int kept;
        int s;
        r = '0;
        if (it.cmd == sdt_pkg::CMD_PURGE) begin
            kept = 0;
            for (int i = 0; i < tbl_count; i++) begin
                if (it.f.now - tbl_time[i] <= age_limit) begin
                    tbl_name[kept] = tbl_name[i];
                    tbl_addr[kept] = tbl_addr[i];
                    tbl_kind[kept] = tbl_kind[i];
                    tbl_chan[kept] = tbl_chan[i];
                    tbl_rssi[kept] = tbl_rssi[i];
                    tbl_lat[kept] = tbl_lat[i];
                    tbl_lon[kept] = tbl_lon[i];
                    tbl_time[kept] = tbl_time[i];
                    kept++;
                end
            end
            r.status = sdt_pkg::ST_PURGED;
            r.count = 7'(kept);
            r.removed = 7'(tbl_count - kept);
            tbl_count = kept;
            tbl_wslot = kept % NENT;
            return r;
        end
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_name[i] == it.f.name && tbl_chan[i] == it.f.channel &&
                tbl_kind[i] == it.f.kind && tbl_addr[i] == it.f.address) begin
                r.status = sdt_pkg::ST_UPDATED;
                r.crossing = (strength_of(it.f.rssi) <= near_thr) &&
                             (strength_of(tbl_rssi[i]) > near_thr);
                r.alert = r.crossing;
                r.slot = 6'(i);
                r.count = 7'(tbl_count);
                tbl_rssi[i] = it.f.rssi;
                tbl_lat[i] = it.f.latitude;
                tbl_lon[i] = it.f.longitude;
                tbl_time[i] = it.f.now;
                return r;
            end
        end
        s = tbl_wslot;
        tbl_name[s] = it.f.name;
        tbl_addr[s] = it.f.address;
        tbl_kind[s] = it.f.kind;
        tbl_chan[s] = it.f.channel;
        tbl_rssi[s] = it.f.rssi;
        tbl_lat[s] = it.f.latitude;
        tbl_lon[s] = it.f.longitude;
        tbl_time[s] = it.f.now;
        tbl_wslot = (s + 1) % NENT;
        if (tbl_count < NENT) tbl_count++;
        r.status = sdt_pkg::ST_INSERTED;
        r.alert = 1'b1;
        r.slot = 6'(s);
        r.count = 7'(tbl_count);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Driver: random gap before each item, then hold valid until accepted.
    int          send_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= $urandom_range(0, 9);
        end else if (s_tvalid && !s_tready) begin
            // holding the offered item
        end else begin
            if (s_tvalid && s_tready) begin
                if (s_tuser == sdt_pkg::CMD_PURGE) purges_sent++;
                else observes_sent++;
                expected_results.push_back(predict_table(pending_items.pop_front()));
            end
            if (s_tvalid && s_tready && send_gap != 0) begin
                s_tvalid <= 1'b0;
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                if (s_tvalid) s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_items[0].cmd;
                s_tdata <= {6'd0, pending_items[0].f};
                send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stalls.
    int recv_gap;
    always @(posedge aclk) begin
        table_result_t got;
        table_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
            hold_off_active <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("ERROR result %0d arrived with nothing expected", results_seen);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.crossing) crossings_seen++;
                    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
                    if (got.alert !== want.alert) report_mismatch("alert", got.alert, want.alert);
                    if (got.crossing !== want.crossing)
                        report_mismatch("crossing", got.crossing, want.crossing);
                    if (got.slot !== want.slot) report_mismatch("slot", got.slot, want.slot);
                    if (got.count !== want.count) report_mismatch("count", got.count, want.count);
                    if (got.removed !== want.removed)
                        report_mismatch("removed", got.removed, want.removed);
                end
            end
            if (hold_off_req && !hold_off_done && !hold_off_active) begin
                hold_off_active <= 1'b1;
                hold_off_left <= 400;
                m_tready <= 1'b0;
            end else if (hold_off_active) begin
                if (hold_off_left == 0) begin
                    hold_off_active <= 1'b0;
                    hold_off_done <= 1'b1;
                end else begin
                    hold_off_left <= hold_off_left - 1;
                end
            end else if (m_tvalid && m_tready) begin
                recv_gap <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 9);
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off_active) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout with %0d results outstanding", expected_results.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic obs_fields_t random_fields(input logic [31:0] now);
        obs_fields_t f;
        f.now = now;
        f.name = $urandom;
        f.address = 48'({$urandom, $urandom});
        f.kind = 2'($urandom_range(0, 3));
        f.channel = 9'($urandom);
        f.rssi = 8'($urandom);
        f.latitude = 31'($urandom);
        f.longitude = $urandom;
        return f;
    endfunction

    task automatic queue_item(input logic cmd, input obs_fields_t f);
        sig_item_t it;
        it.cmd = cmd;
        it.f = f;
        pending_items.push_back(it);
        if (cmd == sdt_pkg::CMD_OBSERVE) begin
            known_keys.push_back(f);
            if (known_keys.size() > 80) void'(known_keys.pop_front());
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == sdt_pkg::CFG_AGE_LIMIT) age_limit = value;
        else near_thr = value[7:0];
    endtask

    // One random phase: mostly observes of known keys with fresh strengths.
    task automatic random_phase(input int n, inout logic [31:0] clock_ms);
        obs_fields_t f;
        for (int i = 0; i < n; i++) begin
            clock_ms += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20000);
            f = random_fields(clock_ms);
            if ($urandom_range(0, 19) == 0) begin
                queue_item(sdt_pkg::CMD_PURGE, f);
            end else begin
                if (known_keys.size() > 0 && $urandom_range(0, 2) != 0) begin
                    obs_fields_t k;
                    k = known_keys[$urandom_range(0, known_keys.size() - 1)];
                    f.name = k.name;
                    f.address = k.address;
                    f.kind = k.kind;
                    f.channel = k.channel;
                    if ($urandom_range(0, 1)) f.rssi = 8'($urandom_range(0, 90) - 100);
                end
                queue_item(sdt_pkg::CMD_OBSERVE, f);
            end
        end
    endtask

    initial begin
        obs_fields_t f;
        logic [31:0] clock_ms;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = sdt_pkg::CFG_AGE_LIMIT;
        cfg_data = '0;
        age_limit = sdt_pkg::AGE_LIMIT_RST;
        near_thr = sdt_pkg::NEAR_THR_RST;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: purge of an empty table, field extremes, a crossing, time wrap.
        queue_item(sdt_pkg::CMD_PURGE, random_fields(32'd0));
        f = '0;
        f.now = 32'hFFFF_FF00;
        f.rssi = 8'sd0;
        queue_item(sdt_pkg::CMD_OBSERVE, f);
        f = '1;
        f.rssi = 8'h80;
        f.channel = 9'h1FF;
        queue_item(sdt_pkg::CMD_OBSERVE, f);
        f.now = 32'd100;
        f.rssi = 8'h80;
        queue_item(sdt_pkg::CMD_OBSERVE, f);
        f.rssi = -8'sd30;
        queue_item(sdt_pkg::CMD_OBSERVE, f);
        f.rssi = -8'sd100;
        queue_item(sdt_pkg::CMD_OBSERVE, f);
        f.rssi = -8'sd50;
        f.latitude = 31'h4000_0000;
        f.longitude = 32'h8000_0000;
        queue_item(sdt_pkg::CMD_OBSERVE, f);
        f = '0;
        f.now = 32'd100;
        queue_item(sdt_pkg::CMD_OBSERVE, f);
        f.now = 32'd60356;
        queue_item(sdt_pkg::CMD_PURGE, f);
        wait_drained();

        // Fill past capacity so the ring overwrites, then purge everything.
        clock_ms = 32'd1000;
        for (int i = 0; i < 70; i++) queue_item(sdt_pkg::CMD_OBSERVE, random_fields(clock_ms + i));
        wait_drained();
        write_register(sdt_pkg::CFG_NEAR_THR, 32'd255);
        // Long receiver stall while the sender keeps offering.
        hold_off_req = 1'b1;
        random_phase(12, clock_ms);
        wait_drained();
        write_register(sdt_pkg::CFG_AGE_LIMIT, 32'd0);
        queue_item(sdt_pkg::CMD_PURGE, random_fields(clock_ms + 5));
        wait_drained();

        write_register(sdt_pkg::CFG_AGE_LIMIT, 32'hFFFF_FFFF);
        write_register(sdt_pkg::CFG_NEAR_THR, 32'd0);
        random_phase(150, clock_ms);
        wait_drained();
        write_register(sdt_pkg::CFG_AGE_LIMIT, 32'd30000);
        write_register(sdt_pkg::CFG_NEAR_THR, 32'd85);
        random_phase(300, clock_ms);
        wait_drained();
        write_register(sdt_pkg::CFG_AGE_LIMIT, $urandom_range(0, 200000));
        write_register(sdt_pkg::CFG_NEAR_THR, $urandom_range(0, 255));
        random_phase(300, clock_ms);
        wait_drained();

        $display("Covered %0d observes and %0d purges, %0d results, %0d crossings seen.",
                 observes_sent, purges_sent, results_seen, crossings_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### signal_detection_table.f
hw/rtl/sdt_pkg.sv
hw/rtl/sdt_ctrl.sv
hw/rtl/sdt_datapath.sv
hw/rtl/signal_detection_table.sv
dv/testbench.sv
